/* rtl/core/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal pipeline
// Widths of the vertex, cross product, dot product, root and quotient paths.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS = 24;
    localparam int VERTS      = 3;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EDGE_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int LO_BITS    = 26;
    localparam int HI_BITS    = CROSS_BITS - LO_BITS;
    localparam int LOP_BITS   = LO_BITS + 1 + COORD_BITS;
    localparam int HIP_BITS   = HI_BITS + COORD_BITS;
    localparam int DOT_BITS   = CROSS_BITS + COORD_BITS + 2;
    localparam int LZ_BITS    = $clog2(CROSS_BITS + 1);
    localparam int MANT_BITS  = 31;
    localparam int SHIFT_LOW  = CROSS_BITS - MANT_BITS;
    localparam int SQ_BITS    = 2 * MANT_BITS;
    localparam int SUM_BITS   = 64;
    localparam int ROOT_STAGES = SUM_BITS / 2;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int FRAC_BITS  = 14;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int NUM_BITS   = MANT_BITS + FRAC_BITS + 2;
    localparam int NORM_BITS  = 16;
    localparam int IN_BITS    = 3 * VERTS * COORD_BITS;
    localparam int OUT_BITS   = VERTS * NORM_BITS;

    typedef logic [VERTS-1:0][COORD_BITS-1:0] vec3_t;
    typedef logic [VERTS-1:0][CROSS_BITS-1:0] cross3_t;
    typedef logic [VERTS-1:0][NORM_BITS-1:0]  norm3_t;

    typedef struct packed {
        logic [VERTS-1:0][MANT_BITS-1:0] m;
        logic [VERTS-1:0]                neg;
        logic                            flip;
        logic                            degen;
    } side_t;

    typedef struct packed {
        logic   flipped;
        logic   degen;
        norm3_t norm;
    } res_t;

    function automatic logic [LZ_BITS-1:0] lead_zeros(input logic [CROSS_BITS-1:0] v);
        logic [LZ_BITS-1:0] cnt;
        cnt = LZ_BITS'(CROSS_BITS);
        for (int i = 0; i < CROSS_BITS; i++)
        begin
            if (v[i])
            begin
                cnt = LZ_BITS'(CROSS_BITS - 1 - i);
            end
        end
        return cnt;
    endfunction

endpackage

/* rtl/core/triangle_face_normal_top.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_top: unit face normal of a fixed-point triangle
// Throughput: one triangle per cycle unless the output buffer is full;
// 60 register stages, all advancing together, feed a two-entry output
// buffer that parts the two sides.
// Reset clears all valid bits and the output buffer; data registers hold.
// ----------------------------------------------------------------------------
module triangle_face_normal_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [tfn_pkg::IN_BITS-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // norm_x, norm_y, norm_z
    output logic [tfn_pkg::OUT_BITS-1:0]  m_tdata,
    // degenerate, flipped
    output logic [1:0]                    m_tuser
);
    import tfn_pkg::*;

    vec3_t               va, vb, vc;
    logic                adv;
    logic                cr_vld, nm_vld, sq_vld, dv_vld;
    cross3_t             cr_n;
    logic                cr_dneg, cr_degen;
    logic [SUM_BITS-1:0] nm_sum;
    side_t               nm_side, sq_side;
    logic [ROOT_BITS-1:0] sq_root;
    res_t                dv_res;
    res_t                head_reg, tail_reg, head_next, tail_next;
    logic                hv_reg, tv_reg, hv_next, tv_next;
    logic                push, pop;

    always_comb
    begin
        for (int i = 0; i < VERTS; i++)
        begin
            va[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
            vb[i] = s_tdata[(VERTS+i)*COORD_BITS +: COORD_BITS];
            vc[i] = s_tdata[(2*VERTS+i)*COORD_BITS +: COORD_BITS];
        end
    end

    assign adv      = !(hv_reg && tv_reg);
    assign s_tready = adv;

    tfn_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .va      (va),
        .vb      (vb),
        .vc      (vc),
        .out_vld (cr_vld),
        .n_out   (cr_n),
        .dot_neg (cr_dneg),
        .degen   (cr_degen)
    );

    tfn_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (cr_vld),
        .n_in     (cr_n),
        .dot_neg  (cr_dneg),
        .degen    (cr_degen),
        .out_vld  (nm_vld),
        .sum_out  (nm_sum),
        .side_out (nm_side)
    );

    tfn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (nm_vld),
        .sum_in   (nm_sum),
        .side_in  (nm_side),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    tfn_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (sq_vld),
        .root    (sq_root),
        .side_in (sq_side),
        .out_vld (dv_vld),
        .res_out (dv_res)
    );

    assign push = dv_vld && adv;
    assign pop  = hv_reg && m_tready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        hv_next   = hv_reg;
        tv_next   = tv_reg;
        if (pop)
        begin
            if (tv_reg)
            begin
                head_next = tail_reg;
                tail_next = dv_res;
                tv_next   = push;
            end
            else
            begin
                head_next = dv_res;
                hv_next   = push;
            end
        end
        else if (push)
        begin
            if (hv_reg)
            begin
                tail_next = dv_res;
                tv_next   = 1'b1;
            end
            else
            begin
                head_next = dv_res;
                hv_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            tv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
            tv_reg <= tv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = hv_reg;
    assign m_tdata  = head_reg.norm;
    assign m_tuser  = {head_reg.flipped, head_reg.degen};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("degenerate result with nonzero normal or flip");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384) &&
            ($signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384) &&
            ($signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
        else $error("normal component out of unit range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg |-> hv_reg)
        else $error("output buffer tail filled while head empty");

endmodule

/* rtl/core/tfn_cross.sv */
// ----------------------------------------------------------------------------
// tfn_cross: edges, cross product and orientation test
// Six stages: edges, partial products, cross product, split dot products,
// partial sums, dot sign.
// ----------------------------------------------------------------------------
module tfn_cross (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  tfn_pkg::vec3_t   va,
    input  tfn_pkg::vec3_t   vb,
    input  tfn_pkg::vec3_t   vc,
    output logic             out_vld,
    output tfn_pkg::cross3_t n_out,
    output logic             dot_neg,
    output logic             degen
);
    import tfn_pkg::*;

    logic [5:0] vld_reg;

    logic signed [EDGE_BITS-1:0]  e1_reg [VERTS];
    logic signed [EDGE_BITS-1:0]  e2_reg [VERTS];
    logic signed [EDGE_BITS-1:0]  e1_next [VERTS];
    logic signed [EDGE_BITS-1:0]  e2_next [VERTS];
    logic signed [COORD_BITS-1:0] a1_reg [VERTS];
    logic signed [COORD_BITS-1:0] a2_reg [VERTS];
    logic signed [COORD_BITS-1:0] a3_reg [VERTS];
    logic signed [PROD_BITS-1:0]  p_reg  [6];
    logic signed [PROD_BITS-1:0]  p_next [6];
    logic signed [CROSS_BITS-1:0] n3_reg [VERTS];
    logic signed [CROSS_BITS-1:0] n3_next [VERTS];
    logic signed [LOP_BITS-1:0]   lo_reg [VERTS];
    logic signed [LOP_BITS-1:0]   lo_next [VERTS];
    logic signed [HIP_BITS-1:0]   hi_reg [VERTS];
    logic signed [HIP_BITS-1:0]   hi_next [VERTS];
    logic signed [DOT_BITS-1:0]   t_reg  [VERTS];
    logic signed [DOT_BITS-1:0]   t_next [VERTS];
    logic signed [DOT_BITS-1:0]   dot_sum;
    cross3_t                      n4_reg, n5_reg, n6_reg;
    logic                         degen4_reg, degen5_reg, degen6_reg;
    logic                         degen4_next;
    logic                         dneg_reg;

    always_comb
    begin
        for (int i = 0; i < VERTS; i++)
        begin
            e1_next[i] = EDGE_BITS'($signed(vb[i])) - EDGE_BITS'($signed(va[i]));
            e2_next[i] = EDGE_BITS'($signed(vc[i])) - EDGE_BITS'($signed(va[i]));
        end
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < VERTS; i++)
        begin
            n3_next[i] = CROSS_BITS'(p_reg[2*i]) - CROSS_BITS'(p_reg[2*i+1]);
            lo_next[i] = $signed({1'b0, n3_reg[i][LO_BITS-1:0]}) * a3_reg[i];
            hi_next[i] = $signed(n3_reg[i][CROSS_BITS-1:LO_BITS]) * a3_reg[i];
            t_next[i]  = (DOT_BITS'(hi_reg[i]) <<< LO_BITS) + DOT_BITS'(lo_reg[i]);
        end
        degen4_next = (n3_reg[0] == '0) && (n3_reg[1] == '0) && (n3_reg[2] == '0);
        dot_sum     = t_reg[0] + t_reg[1] + t_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < VERTS; i++)
            begin
                e1_reg[i] <= e1_next[i];
                e2_reg[i] <= e2_next[i];
                a1_reg[i] <= $signed(va[i]);
                a2_reg[i] <= a1_reg[i];
                a3_reg[i] <= a2_reg[i];
                n3_reg[i] <= n3_next[i];
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
                t_reg[i]  <= t_next[i];
                n4_reg[i] <= n3_reg[i];
            end
            for (int k = 0; k < 6; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            n5_reg     <= n4_reg;
            n6_reg     <= n5_reg;
            degen4_reg <= degen4_next;
            degen5_reg <= degen4_reg;
            degen6_reg <= degen5_reg;
            dneg_reg   <= dot_sum[DOT_BITS-1];
        end
    end

    assign out_vld = vld_reg[5];
    assign n_out   = n6_reg;
    assign dot_neg = dneg_reg;
    assign degen   = degen6_reg;

endmodule

/* rtl/core/tfn_norm.sv */
// ----------------------------------------------------------------------------
// tfn_norm: flip, magnitude alignment and sum of squares
// Five stages: magnitudes, leading zero count, alignment, squares, sum.
// ----------------------------------------------------------------------------
module tfn_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  tfn_pkg::cross3_t              n_in,
    input  logic                          dot_neg,
    input  logic                          degen,
    output logic                          out_vld,
    output logic [tfn_pkg::SUM_BITS-1:0]  sum_out,
    output tfn_pkg::side_t                side_out
);
    import tfn_pkg::*;

    logic [4:0] vld_reg;

    logic [CROSS_BITS-1:0] mag7_reg [VERTS];
    logic [CROSS_BITS-1:0] mag7_next [VERTS];
    logic [CROSS_BITS-1:0] mag8_reg [VERTS];
    logic [CROSS_BITS-1:0] mag_or;
    logic [CROSS_BITS-1:0] shifted [VERTS];
    logic [VERTS-1:0]      neg7_reg, neg8_reg, neg7_next;
    logic                  flip7_reg, flip8_reg, degen7_reg, degen8_reg;
    logic [LZ_BITS-1:0]    lz_reg;
    logic [SQ_BITS-1:0]    sq_reg [VERTS];
    logic [SQ_BITS-1:0]    sq_next [VERTS];
    side_t                 side9_reg, side10_reg, side11_reg, side9_next;
    logic [SUM_BITS-1:0]   sum_reg;

    always_comb
    begin
        mag_or     = '0;
        side9_next = '0;
        for (int i = 0; i < VERTS; i++)
        begin
            mag7_next[i] = n_in[i][CROSS_BITS-1] ? CROSS_BITS'(-$signed(n_in[i])) : n_in[i];
            neg7_next[i] = n_in[i][CROSS_BITS-1] ^ dot_neg;
            mag_or       = mag_or | mag7_reg[i];
            shifted[i]   = mag8_reg[i] << lz_reg;
            side9_next.m[i] = shifted[i][CROSS_BITS-1 -: MANT_BITS];
            sq_next[i]   = side9_reg.m[i] * side9_reg.m[i];
        end
        side9_next.neg   = neg8_reg;
        side9_next.flip  = flip8_reg;
        side9_next.degen = degen8_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < VERTS; i++)
            begin
                mag7_reg[i] <= mag7_next[i];
                mag8_reg[i] <= mag7_reg[i];
                sq_reg[i]   <= sq_next[i];
            end
            neg7_reg   <= neg7_next;
            flip7_reg  <= dot_neg;
            degen7_reg <= degen;
            neg8_reg   <= neg7_reg;
            flip8_reg  <= flip7_reg;
            degen8_reg <= degen7_reg;
            lz_reg     <= lead_zeros(mag_or);
            side9_reg  <= side9_next;
            side10_reg <= side9_reg;
            side11_reg <= side10_reg;
            sum_reg    <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
        end
    end

    assign out_vld  = vld_reg[4];
    assign sum_out  = sum_reg;
    assign side_out = side11_reg;

endmodule

/* rtl/core/tfn_sqrt.sv */
// ----------------------------------------------------------------------------
// tfn_sqrt: pipelined integer square root
// One result bit per stage, digit by digit, over the 64-bit sum of squares.
// ----------------------------------------------------------------------------
module tfn_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  logic [tfn_pkg::SUM_BITS-1:0]   sum_in,
    input  tfn_pkg::side_t                 side_in,
    output logic                           out_vld,
    output logic [tfn_pkg::ROOT_BITS-1:0]  root,
    output tfn_pkg::side_t                 side_out
);
    import tfn_pkg::*;

    logic [ROOT_STAGES-1:0] vld_reg;
    logic [SUM_BITS-1:0]    rem_reg  [ROOT_STAGES];
    logic [SUM_BITS-1:0]    res_reg  [ROOT_STAGES];
    side_t                  side_reg [ROOT_STAGES];
    logic [SUM_BITS-1:0]    rem_src  [ROOT_STAGES];
    logic [SUM_BITS-1:0]    res_src  [ROOT_STAGES];
    side_t                  side_src [ROOT_STAGES];
    logic [SUM_BITS-1:0]    trial    [ROOT_STAGES];
    logic [SUM_BITS-1:0]    rem_next [ROOT_STAGES];
    logic [SUM_BITS-1:0]    res_next [ROOT_STAGES];
    logic [SUM_BITS-1:0]    bitv     [ROOT_STAGES];

    always_comb
    begin
        rem_src[0]  = sum_in;
        res_src[0]  = '0;
        side_src[0] = side_in;
        for (int j = 1; j < ROOT_STAGES; j++)
        begin
            rem_src[j]  = rem_reg[j-1];
            res_src[j]  = res_reg[j-1];
            side_src[j] = side_reg[j-1];
        end
        for (int j = 0; j < ROOT_STAGES; j++)
        begin
            bitv[j]  = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * j);
            trial[j] = res_src[j] + bitv[j];
            if (rem_src[j] >= trial[j])
            begin
                rem_next[j] = rem_src[j] - trial[j];
                res_next[j] = (res_src[j] >> 1) + bitv[j];
            end
            else
            begin
                rem_next[j] = rem_src[j];
                res_next[j] = res_src[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ROOT_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < ROOT_STAGES; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                res_reg[j]  <= res_next[j];
                side_reg[j] <= side_src[j];
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_STAGES-1];
    assign root     = res_reg[ROOT_STAGES-1][ROOT_BITS-1:0];
    assign side_out = side_reg[ROOT_STAGES-1];

endmodule

/* rtl/core/tfn_div.sv */
// ----------------------------------------------------------------------------
// tfn_div: pipelined rounding divider and sign restore
// Rounded numerators, one quotient bit per stage for all three components,
// then sign and degenerate handling in a final stage.
// ----------------------------------------------------------------------------
module tfn_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  logic [tfn_pkg::ROOT_BITS-1:0]  root,
    input  tfn_pkg::side_t                 side_in,
    output logic                           out_vld,
    output tfn_pkg::res_t                  res_out
);
    import tfn_pkg::*;

    localparam int DSTAGES = QUOT_BITS + 1;

    logic [DSTAGES:0]                        vld_reg;
    logic [VERTS-1:0][NUM_BITS-1:0]          rem_reg  [DSTAGES];
    logic [VERTS-1:0][NUM_BITS-1:0]          rem_next [DSTAGES];
    logic [VERTS-1:0][QUOT_BITS-1:0]         q_reg    [DSTAGES];
    logic [VERTS-1:0][QUOT_BITS-1:0]         q_next   [DSTAGES];
    logic [ROOT_BITS-1:0]                    dvs_reg  [DSTAGES];
    logic [ROOT_BITS-1:0]                    dvs_next [DSTAGES];
    logic [VERTS-1:0]                        neg_reg  [DSTAGES];
    logic [VERTS-1:0]                        neg_next [DSTAGES];
    logic                                    flip_reg [DSTAGES];
    logic                                    flip_next [DSTAGES];
    logic                                    degen_reg [DSTAGES];
    logic                                    degen_next [DSTAGES];
    logic [NUM_BITS-1:0]                     dshift [DSTAGES];
    res_t                                    res_reg, res_next;

    always_comb
    begin
        for (int i = 0; i < VERTS; i++)
        begin
            rem_next[0][i] = (NUM_BITS'(side_in.m[i]) << FRAC_BITS) + NUM_BITS'(root >> 1);
        end
        q_next[0]     = '0;
        dvs_next[0]   = root;
        neg_next[0]   = side_in.neg;
        flip_next[0]  = side_in.flip;
        degen_next[0] = side_in.degen;
        dshift[0]     = '0;
        for (int s = 1; s < DSTAGES; s++)
        begin
            dshift[s]     = NUM_BITS'(dvs_reg[s-1]) << (QUOT_BITS - s);
            dvs_next[s]   = dvs_reg[s-1];
            neg_next[s]   = neg_reg[s-1];
            flip_next[s]  = flip_reg[s-1];
            degen_next[s] = degen_reg[s-1];
            for (int i = 0; i < VERTS; i++)
            begin
                rem_next[s][i] = rem_reg[s-1][i];
                q_next[s][i]   = q_reg[s-1][i];
                if (rem_reg[s-1][i] >= dshift[s])
                begin
                    rem_next[s][i]               = rem_reg[s-1][i] - dshift[s];
                    q_next[s][i][QUOT_BITS - s]  = 1'b1;
                end
            end
        end
        res_next.flipped = flip_reg[DSTAGES-1];
        res_next.degen   = degen_reg[DSTAGES-1];
        for (int i = 0; i < VERTS; i++)
        begin
            if (degen_reg[DSTAGES-1])
            begin
                res_next.norm[i] = '0;
            end
            else if (neg_reg[DSTAGES-1][i])
            begin
                res_next.norm[i] = -NORM_BITS'(q_reg[DSTAGES-1][i]);
            end
            else
            begin
                res_next.norm[i] = NORM_BITS'(q_reg[DSTAGES-1][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DSTAGES-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DSTAGES; s++)
            begin
                rem_reg[s]   <= rem_next[s];
                q_reg[s]     <= q_next[s];
                dvs_reg[s]   <= dvs_next[s];
                neg_reg[s]   <= neg_next[s];
                flip_reg[s]  <= flip_next[s];
                degen_reg[s] <= degen_next[s];
            end
            res_reg <= res_next;
        end
    end

    assign out_vld = vld_reg[DSTAGES];
    assign res_out = res_reg;

endmodule

/* sim/tb_triangle_face_normal_top.sv */
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_top: testbench for the triangle face normal pipeline
// Directed triangles (degenerate, flipped, zero-dot, extreme coordinates) and
// random ones stream through the block under random gaps and backpressure.
// Each normal is predicted in exact wide arithmetic and checked per field.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tfn_pkg::*;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
        logic        flip;
    } normal_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;
    logic [1:0]           m_tuser;

    normal_t   normal_queue[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        hold_cycles = 0;
    bit        hold_req;
    bit        hold_done = 1'b0;
    bit        busy_rx = 1'b0;
    bit        fail_seen = 1'b0;

    triangle_face_normal_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int bit_len(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= v)
            begin
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic normal_t face_normal(logic [IN_BITS-1:0] tri_bits);
        logic signed [127:0] v[9];
        logic signed [127:0] e1[3];
        logic signed [127:0] e2[3];
        logic signed [127:0] n[3];
        logic signed [127:0] dot;
        logic [127:0]        mag[3];
        logic [63:0]         m[3];
        logic [63:0]         sum;
        logic [63:0]         len;
        logic [63:0]         q;
        logic [15:0]         qs[3];
        int                  k;
        normal_t             r;
        for (int i = 0; i < 9; i++)
        begin
            v[i] = signed'(tri_bits[i*COORD_BITS +: COORD_BITS]);
        end
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = v[3+i] - v[i];
            e2[i] = v[6+i] - v[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0};
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        dot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
        r.flip = dot < 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (r.flip)
            begin
                n[i] = -n[i];
            end
            mag[i] = n[i] < 0 ? -n[i] : n[i];
            if (bit_len(mag[i]) > k)
            begin
                k = bit_len(mag[i]);
            end
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (k > 31) ? 64'(mag[i] >> (k - 31)) : 64'(mag[i] << (31 - k));
            sum += m[i] * m[i];
        end
        len = root64(sum);
        if (len == 0)
        begin
            len = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            if (n[i] < 0)
            begin
                q = 64'd0 - q;
            end
            qs[i] = q[15:0];
        end
        r.nx = qs[0];
        r.ny = qs[1];
        r.nz = qs[2];
        return r;
    endfunction

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
        end
        repeat (gap) @(posedge clk);
    endtask

    task automatic send_triangle(logic [IN_BITS-1:0] tri_bits);
        s_tvalid <= 1'b1;
        s_tdata  <= tri_bits;
        normal_queue = {normal_queue, face_normal(tri_bits)};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pause_sender();
    endtask

    function automatic logic [IN_BITS-1:0] pack_tri(int c[9]);
        logic [IN_BITS-1:0] t;
        for (int i = 0; i < 9; i++)
        begin
            t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(c[i]);
        end
        return t;
    endfunction

    function automatic logic [IN_BITS-1:0] random_tri();
        logic [IN_BITS-1:0] t;
        int                 base[3];
        int                 span;
        case ($urandom_range(0, 3))
            0:
            begin
                for (int i = 0; i < 9; i++)
                begin
                    t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
                end
            end
            1:
            begin
                span = 1 << $urandom_range(0, 22);
                for (int i = 0; i < 3; i++)
                begin
                    base[i] = int'($urandom_range(0, 2 * (1 << 22))) - (1 << 22);
                end
                for (int i = 0; i < 9; i++)
                begin
                    t[i*COORD_BITS +: COORD_BITS] =
                        COORD_BITS'(base[i%3] + int'($urandom_range(0, span)) - span / 2);
                end
            end
            2:
            begin
                for (int i = 0; i < 9; i++)
                begin
                    t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(int'($urandom_range(0, 8)) - 4);
                end
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
                    t[(3+i)*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
                end
                for (int i = 0; i < 3; i++)
                begin
                    t[(6+i)*COORD_BITS +: COORD_BITS] = (i == 0)
                        ? t[(3+i)*COORD_BITS +: COORD_BITS]
                        : t[i*COORD_BITS +: COORD_BITS];
                end
                if ($urandom_range(0, 1))
                begin
                    t[6*COORD_BITS +: 3*COORD_BITS] = t[3*COORD_BITS +: 3*COORD_BITS];
                end
            end
        endcase
        return t;
    endfunction

    task automatic test_directed();
        int mx;
        int mn;
        mx = (1 << 23) - 1;
        mn = -(1 << 23);
        send_triangle(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_triangle(pack_tri('{5, 6, 7, 5, 6, 7, 1, 2, 3}));
        send_triangle(pack_tri('{1, 1, 1, 2, 2, 2, 3, 3, 3}));
        send_triangle(pack_tri('{0, 0, 4096, 4096, 0, 4096, 0, 4096, 4096}));
        send_triangle(pack_tri('{0, 0, 4096, 0, 4096, 4096, 4096, 0, 4096}));
        send_triangle(pack_tri('{0, 0, 0, 4096, 0, 0, 0, 4096, 0}));
        send_triangle(pack_tri('{mn, mn, mn, mx, mn, mn, mn, mx, mn}));
        send_triangle(pack_tri('{mx, mx, mx, mn, mx, mx, mx, mn, mx}));
        send_triangle(pack_tri('{mn, mx, mn, mx, mn, mx, mx, mx, mn}));
        send_triangle(pack_tri('{mx, 0, 0, 0, mx, 0, 0, 0, mx}));
        send_triangle(pack_tri('{mn, 0, 0, 0, mn, 0, 0, 0, mn}));
        send_triangle(pack_tri('{-1, -1, -1, 0, 0, 0, 1, 0, 0}));
        send_triangle(pack_tri('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
        send_triangle(pack_tri('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
        send_triangle(pack_tri('{3, 0, 0, 3, 1, 0, 3, 0, 1}));
        send_triangle(pack_tri('{mx, mn, 1, -1, mx, mn, mn, 1, mx}));
        send_triangle(pack_tri('{1, 2, 0, 2, 1, 0, 0, 0, 0}));
        send_triangle({IN_BITS{1'b1}});
        send_triangle({(IN_BITS/2){2'b01}});
        send_triangle({(IN_BITS/2){2'b10}});
    endtask

    task automatic test_random();
        for (int i = 0; i < 750; i++)
        begin
            send_triangle(random_tri());
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 80; i++)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= random_tri();
            @(negedge clk);
            normal_queue = {normal_queue, face_normal(s_tdata)};
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 299)
            begin
                hold_done <= 1'b1;
            end
        end
        else if (busy_rx)
        begin
            m_tready <= ($urandom_range(0, 9) != 0) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 30) == 0)
            begin
                busy_rx <= 1'b0;
            end
        end
        else
        begin
            m_tready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 60) == 0)
            begin
                busy_rx <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (normal_queue.size() == 0)
            begin
                $display("%0t: unexpected normal %h user %b", $realtime, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = normal_queue.pop_front();
                if (m_tdata[15:0] !== want.nx)
                begin
                    $display("%0t: norm_x expected %h actual %h", $realtime, want.nx,
                             m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== want.ny)
                begin
                    $display("%0t: norm_y expected %h actual %h", $realtime, want.ny,
                             m_tdata[31:16]);
                    error_count++;
                end
                if (m_tdata[47:32] !== want.nz)
                begin
                    $display("%0t: norm_z expected %h actual %h", $realtime, want.nz,
                             m_tdata[47:32]);
                    error_count++;
                end
                if (m_tuser[0] !== want.degen)
                begin
                    $display("%0t: degenerate expected %b actual %b", $realtime, want.degen,
                             m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.flip)
                begin
                    $display("%0t: flipped expected %b actual %b", $realtime, want.flip,
                             m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 400000 && !fail_seen)
        begin
            fail_seen <= 1'b1;
            $display("timeout with %0d normals pending", normal_queue.size());
            $display("triangle_face_normal_top test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        hold_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;
        while (normal_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("triangle_face_normal_top test passed");
        end
        else
        begin
            $display("triangle_face_normal_top test failed");
        end
        $finish;
    end

endmodule
